@@ rtl/core/rtp_pkg.sv @@
// ----------------------------------------------------------------------------
// rtp_pkg
// Shared constants, codes and types of the H.264 RTP packetiser.
// ----------------------------------------------------------------------------
package rtp_pkg;

  // Delay buffer and the queue of closed units.
  localparam int BUF_DEPTH = 2048;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = $clog2(BUF_DEPTH + 1);
  localparam int Q_DEPTH   = BUF_DEPTH + 1;
  localparam int Q_AW      = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  // Field widths.
  localparam int MP_W  = 12;
  localparam int TS_W  = 16;
  localparam int PT_W  = 7;
  localparam int CNT_W = 12;
  localparam int CMP_W = ((LEN_W > MP_W) ? LEN_W : MP_W) + 1;

  // Result queue towards the output channel.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // Most result items caused by one input item.
  localparam logic [1:0] RUN_MAX = 2'd3;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TS_INC      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYP = 2'd2;

  // Input opcodes.
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
  localparam logic [OP_W-1:0] OP_EOS  = 2'd1;

  // Reset values of the registers.
  localparam int TICK_RATE  = 90000;
  localparam int FRAME_RATE = 15;
  localparam logic [MP_W-1:0] MP_RESET = 12'd1400;
  localparam logic [TS_W-1:0] TS_RESET = TS_W'(TICK_RATE / FRAME_RATE);
  localparam logic [PT_W-1:0] PT_RESET = 7'd96;

  // Start code and FU-A header fields.
  localparam logic [7:0] START_CODE_BYTE = 8'h01;
  localparam logic [7:0] FU_NRI_MASK     = 8'h60;
  localparam logic [7:0] FU_TYPE         = 8'd28;
  localparam logic [7:0] FU_TYPE_MASK    = 8'h1f;
  localparam logic [7:0] FU_START        = 8'h80;
  localparam logic [7:0] FU_END          = 8'h40;

  // Command from the front end to the packet engine, one per cycle.
  typedef struct packed {
    logic       new_run;
    logic       idle;
    logic       store;
    logic [7:0] data;
    logic       close;
    logic       close_push;
    logic       in_nal;
  } rtp_cmd_t;

  // One result item.
  typedef struct packed {
    logic [7:0]      data;
    logic            first;
    logic            last;
    logic            marker;
    logic [TS_W-1:0] time_step;
    logic [PT_W-1:0] ptype;
    logic            last_of_run;
  } rtp_res_t;

endpackage

@@ rtl/core/rtp_ram.sv @@
// ----------------------------------------------------------------------------
// rtp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ rtl/core/rtp_front.sv @@
// ----------------------------------------------------------------------------
// rtp_front
// Accepts input items, finds Annex B start codes and turns each item into a
// short sequence of store and close commands, one per cycle.
// ----------------------------------------------------------------------------
module rtp_front import rtp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [OP_W-1:0] in_opcode,
  input  logic [7:0]      in_stream_byte,
  input  logic            back_rdy,
  output rtp_cmd_t        cmd
);

  logic [23:0] win_r, win_nxt;
  logic        in_nal_r, in_nal_nxt;
  logic [1:0]  pz_r, pz_nxt;
  logic        pb_r, pb_nxt;
  logic [7:0]  pbd_r, pbd_nxt;
  logic        pc_r, pc_nxt;
  logic        pcs_r, pcs_nxt;

  logic        idle, acc;
  logic [1:0]  held;
  logic [1:0]  a_nz, s_nz;
  logic        a_b, s_b, a_c, s_c, a_cs, s_cs;
  logic [7:0]  a_bd, s_bd;
  logic        st, cl;
  logic [7:0]  sd;

  assign idle     = (pz_r == 2'd0) && !pb_r && !pc_r;
  assign in_ready = idle && back_rdy;
  assign acc      = in_valid && in_ready;

  // Zeros held back in the window ahead of a possible start code.
  always_comb begin
    held = 2'd0;
    if (win_r[7:0] == 8'd0) begin
      held = 2'd1;
      if (win_r[15:8] == 8'd0) begin
        held = 2'd2;
        if (win_r[23:16] == 8'd0) begin
          held = 2'd3;
        end
      end
    end
  end

  // Classify the arriving item into zeros to store, a byte and a close.
  always_comb begin
    a_nz    = 2'd0;
    a_b     = 1'b0;
    a_bd    = in_stream_byte;
    a_c     = 1'b0;
    a_cs    = 1'b0;
    win_nxt = win_r;
    if (acc) begin
      case (in_opcode)
        OP_BYTE: begin
          win_nxt = {win_r[15:0], in_stream_byte};
          if (in_stream_byte == START_CODE_BYTE && held >= 2'd2) begin
            a_c  = 1'b1;
            a_cs = 1'b1;
          end else if (in_stream_byte == 8'd0) begin
            a_nz = (held == 2'd3) ? 2'd1 : 2'd0;
          end else begin
            a_nz = held;
            a_b  = 1'b1;
          end
        end
        OP_EOS: begin
          win_nxt = '1;
          if (in_nal_r) begin
            a_nz = held;
            a_c  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Carry out one command a cycle, the rest stays pending.
  always_comb begin
    s_nz = acc ? a_nz : pz_r;
    s_b  = acc ? a_b  : pb_r;
    s_bd = acc ? a_bd : pbd_r;
    s_c  = acc ? a_c  : pc_r;
    s_cs = acc ? a_cs : pcs_r;
    st         = 1'b0;
    sd         = 8'd0;
    cl         = 1'b0;
    in_nal_nxt = in_nal_r;
    pz_nxt     = 2'd0;
    pb_nxt     = 1'b0;
    pbd_nxt    = s_bd;
    pc_nxt     = 1'b0;
    pcs_nxt    = 1'b0;
    if (s_nz != 2'd0) begin
      st      = 1'b1;
      pz_nxt  = s_nz - 2'd1;
      pb_nxt  = s_b;
      pc_nxt  = s_c;
      pcs_nxt = s_cs;
    end else if (s_b) begin
      st      = 1'b1;
      sd      = s_bd;
      pc_nxt  = s_c;
      pcs_nxt = s_cs;
    end else if (s_c) begin
      cl         = 1'b1;
      in_nal_nxt = s_cs;
    end
  end

  always_comb begin
    cmd.new_run    = acc;
    cmd.idle       = idle;
    cmd.store      = st && in_nal_r;
    cmd.data       = sd;
    cmd.close      = cl;
    cmd.close_push = in_nal_r;
    cmd.in_nal     = in_nal_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r    <= '1;
      in_nal_r <= 1'b0;
      pz_r     <= 2'd0;
      pb_r     <= 1'b0;
      pc_r     <= 1'b0;
      pcs_r    <= 1'b0;
    end else begin
      win_r    <= win_nxt;
      in_nal_r <= in_nal_nxt;
      pz_r     <= pz_nxt;
      pb_r     <= pb_nxt;
      pc_r     <= pc_nxt;
      pcs_r    <= pcs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pbd_r <= pbd_nxt;
  end

endmodule

@@ rtl/core/rtp_outq.sv @@
// ----------------------------------------------------------------------------
// rtp_outq
// Small result queue that parts the packet engine from the output channel.
// ----------------------------------------------------------------------------
module rtp_outq import rtp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  rtp_res_t push_data,
  output logic     full,
  output logic     out_valid,
  input  logic     out_ready,
  output rtp_res_t head
);

  rtp_res_t             mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]   wp_r, rp_r;
  logic [OUTQ_CW-1:0]   cnt_r;
  logic                 pop;

  assign full      = cnt_r == OUTQ_CW'(OUTQ_DEPTH);
  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign head      = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == OUTQ_AW'(OUTQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + OUTQ_CW'(push) - OUTQ_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

@@ rtl/core/rtp_back.sv @@
// ----------------------------------------------------------------------------
// rtp_back
// Packet engine: delay buffer, queue of closed units and the state machine
// emitting single packets and FU-A fragments one step a cycle unless stalled.
// ----------------------------------------------------------------------------
module rtp_back import rtp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  rtp_cmd_t             cmd,
  output logic                 back_rdy,
  output logic                 res_push,
  output rtp_res_t             res,
  input  logic                 res_full
);

  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] HDR_FUH  = 2'd1;
  localparam logic [1:0] HDR_FUI  = 2'd2;

  // Configuration.
  logic [MP_W-1:0] mp_r;
  logic [TS_W-1:0] ts_r;
  logic [PT_W-1:0] pt_r;

  // Delay buffer bookkeeping.
  logic [BUF_AW-1:0] wr_pos_r, wr_pos_nxt, rd_pos_r, rd_pos_nxt;
  logic [LEN_W-1:0]  fill_r, fill_nxt, open_left_r, open_left_nxt;
  logic [CNT_W-1:0]  nal_count_r, nal_count_nxt;
  logic              byp_v_r, byp_v_nxt;
  logic [7:0]        byp_d_r, d_q;
  logic              d_we;

  // Queue of closed units; the head lives in registers or on the read port.
  logic [Q_AW-1:0]   q_head_r, q_head_nxt, q_tail_r, q_tail_nxt;
  logic [QCNT_W-1:0] q_num_r, q_num_nxt;
  logic [LEN_W-1:0]  hlen_r, hlen_nxt;
  logic              hshort_r, hshort_nxt, use_ram_r, use_ram_nxt;
  logic              q_we;
  logic [LEN_W:0]    q_wd, q_q;

  // Engine state.
  logic              eng_r, eng_nxt, inpkt_r, inpkt_nxt;
  logic              firstp_r, firstp_nxt, mark_r, mark_nxt;
  logic              pstart_r, pstart_nxt;
  logic [1:0]        hdr_r, hdr_nxt;
  logic [LEN_W-1:0]  fc_r, fc_nxt;
  logic [7:0]        nhdr_r, nhdr_nxt;
  logic [1:0]        run_r, run_nxt;
  logic              held_v_r, held_v_nxt;
  rtp_res_t          held_r, held_nxt;

  // Decode helpers.
  logic [LEN_W-1:0]  hlen, avail, eff, fc_o;
  logic              hshort, qne, start_open, brk, run_end, iter, flush;
  logic              do_take, do_done, do_push, push_short, last;
  logic [LEN_W-1:0]  push_len;
  logic [7:0]        tb_data, ob;
  logic [1:0]        hdr_o;
  rtp_res_t          r;

  rtp_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_dly (
    .clk   (clk),
    .we    (d_we),
    .waddr (wr_pos_r),
    .wdata (cmd.data),
    .raddr (rd_pos_nxt),
    .rdata (d_q)
  );

  rtp_ram #(.WIDTH(LEN_W + 1), .DEPTH(Q_DEPTH)) u_unitq (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_tail_r),
    .wdata (q_wd),
    .raddr (q_head_nxt),
    .rdata (q_q)
  );

  // Head of the unit queue, clamped payload size and the stop condition.
  always_comb begin
    hlen    = use_ram_r ? q_q[LEN_W-1:0] : hlen_r;
    hshort  = use_ram_r ? q_q[LEN_W] : hshort_r;
    qne     = q_num_r != '0;
    avail   = qne ? hlen : open_left_r;
    if (mp_r == '0) begin
      eff = LEN_W'(1);
    end else if (CMP_W'(mp_r) > CMP_W'(BUF_DEPTH - 1)) begin
      eff = LEN_W'(BUF_DEPTH - 1);
    end else begin
      eff = LEN_W'(mp_r);
    end
    start_open = cmd.in_nal && (nal_count_r >= mp_r) && (open_left_r != '0);
    brk = (!eng_r && !qne && !start_open) ||
          (eng_r && !inpkt_r && !qne && !(open_left_r > eff));
    run_end  = (run_r == RUN_MAX) || brk;
    back_rdy = run_end && (!held_v_r || !res_full);
    iter     = cmd.idle && !cmd.new_run && !run_end && !res_full;
    flush    = cmd.idle && run_end && held_v_r && !res_full;
    tb_data  = (fill_r != '0) ? (byp_v_r ? byp_d_r : d_q) : 8'd0;
  end

  // Next state: front commands, then one engine step.
  always_comb begin
    wr_pos_nxt    = wr_pos_r;
    rd_pos_nxt    = rd_pos_r;
    fill_nxt      = fill_r;
    open_left_nxt = open_left_r;
    nal_count_nxt = nal_count_r;
    q_head_nxt    = q_head_r;
    q_tail_nxt    = q_tail_r;
    q_num_nxt     = q_num_r;
    hlen_nxt      = hlen_r;
    hshort_nxt    = hshort_r;
    use_ram_nxt   = use_ram_r;
    eng_nxt       = eng_r;
    inpkt_nxt     = inpkt_r;
    firstp_nxt    = firstp_r;
    mark_nxt      = mark_r;
    pstart_nxt    = pstart_r;
    hdr_nxt       = hdr_r;
    fc_nxt        = fc_r;
    nhdr_nxt      = nhdr_r;
    run_nxt       = run_r;
    held_v_nxt    = held_v_r;
    held_nxt      = held_r;
    d_we          = 1'b0;
    q_we          = 1'b0;
    q_wd          = '0;
    res_push      = 1'b0;
    res           = held_r;
    do_take       = 1'b0;
    do_done       = 1'b0;
    do_push       = 1'b0;
    push_short    = 1'b0;
    push_len      = open_left_r;
    last          = 1'b0;
    ob            = 8'd0;
    hdr_o         = HDR_NONE;
    fc_o          = fc_r;
    r             = held_r;

    // Store one unit byte.
    if (cmd.store) begin
      if (nal_count_r != '1) begin
        nal_count_nxt = nal_count_r + 1'b1;
      end
      if (fill_r < LEN_W'(BUF_DEPTH)) begin
        d_we          = 1'b1;
        wr_pos_nxt    = (wr_pos_r == BUF_AW'(BUF_DEPTH - 1)) ? '0 : wr_pos_r + 1'b1;
        fill_nxt      = fill_r + 1'b1;
        open_left_nxt = open_left_r + 1'b1;
      end
    end

    // Close the open unit and queue its length.
    if (cmd.close) begin
      if (cmd.close_push) begin
        if (eng_r && !qne) begin
          do_push = 1'b1;
        end else if (open_left_r != '0) begin
          do_push    = 1'b1;
          push_short = nal_count_r < mp_r;
        end
      end
      nal_count_nxt = '0;
      open_left_nxt = '0;
    end
    if (do_push && (q_num_r < QCNT_W'(Q_DEPTH))) begin
      q_we       = 1'b1;
      q_wd       = {push_short, push_len};
      q_tail_nxt = (q_tail_r == Q_AW'(Q_DEPTH - 1)) ? '0 : q_tail_r + 1'b1;
      q_num_nxt  = q_num_r + 1'b1;
      if (!qne) begin
        hlen_nxt    = push_len;
        hshort_nxt  = push_short;
        use_ram_nxt = 1'b0;
      end
    end

    if (cmd.new_run) begin
      run_nxt = 2'd0;
    end

    // One engine step.
    if (iter) begin
      if (!eng_r) begin
        if (qne && hlen == '0) begin
          do_done = 1'b1;
        end else if (qne && hshort) begin
          fc_nxt     = hlen;
          mark_nxt   = 1'b1;
          hdr_nxt    = HDR_NONE;
          inpkt_nxt  = 1'b1;
          pstart_nxt = 1'b1;
          firstp_nxt = 1'b1;
          eng_nxt    = 1'b1;
        end else begin
          do_take    = 1'b1;
          nhdr_nxt   = tb_data;
          eng_nxt    = 1'b1;
          firstp_nxt = 1'b1;
          inpkt_nxt  = 1'b0;
        end
      end else if (!inpkt_r) begin
        if (qne) begin
          fc_nxt   = (avail < eff) ? avail : eff;
          mark_nxt = avail <= eff;
        end else begin
          fc_nxt   = eff;
          mark_nxt = 1'b0;
        end
        hdr_nxt    = HDR_FUI;
        inpkt_nxt  = 1'b1;
        pstart_nxt = 1'b1;
      end else begin
        unique case (hdr_r)
          HDR_FUI: begin
            ob    = (nhdr_r & FU_NRI_MASK) | FU_TYPE;
            hdr_o = HDR_FUH;
          end
          HDR_FUH: begin
            ob    = (nhdr_r & FU_TYPE_MASK) | (firstp_r ? FU_START : 8'd0) |
                    (mark_r ? FU_END : 8'd0);
            hdr_o = HDR_NONE;
          end
          default: begin
            ob      = tb_data;
            do_take = 1'b1;
            if (fc_r != '0) begin
              fc_o = fc_r - 1'b1;
            end
            hdr_o = HDR_NONE;
          end
        endcase
        last          = (hdr_o == HDR_NONE) && (fc_o == '0);
        r.data        = ob;
        r.first       = pstart_r;
        r.last        = last;
        r.marker      = mark_r;
        r.time_step   = firstp_r ? ts_r : '0;
        r.ptype       = pt_r;
        r.last_of_run = 1'b0;
        pstart_nxt    = 1'b0;
        hdr_nxt       = hdr_o;
        fc_nxt        = fc_o;
        run_nxt       = run_r + 1'b1;
        if (held_v_r) begin
          res_push        = 1'b1;
          res             = held_r;
          res.last_of_run = 1'b0;
        end
        held_nxt   = r;
        held_v_nxt = 1'b1;
        if (last) begin
          inpkt_nxt  = 1'b0;
          firstp_nxt = 1'b0;
          do_done    = mark_r;
        end
      end
    end

    // Read one byte from the delay buffer.
    if (do_take && fill_r != '0) begin
      rd_pos_nxt = (rd_pos_r == BUF_AW'(BUF_DEPTH - 1)) ? '0 : rd_pos_r + 1'b1;
      fill_nxt   = fill_r - 1'b1;
      if (qne) begin
        if (hlen != '0) begin
          hlen_nxt    = hlen - 1'b1;
          use_ram_nxt = 1'b0;
        end
      end else if (open_left_r != '0) begin
        open_left_nxt = open_left_r - 1'b1;
      end
    end

    // Finish the unit at the head.
    if (do_done) begin
      if (qne) begin
        q_head_nxt  = (q_head_r == Q_AW'(Q_DEPTH - 1)) ? '0 : q_head_r + 1'b1;
        q_num_nxt   = q_num_r - 1'b1;
        use_ram_nxt = q_num_r > QCNT_W'(1);
      end
      eng_nxt   = 1'b0;
      inpkt_nxt = 1'b0;
    end

    // The held result closes the run.
    if (flush) begin
      res_push        = 1'b1;
      res             = held_r;
      res.last_of_run = 1'b1;
      held_v_nxt      = 1'b0;
    end

    byp_v_nxt = d_we && (wr_pos_r == rd_pos_nxt);
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r <= MP_RESET;
      ts_r <= TS_RESET;
      pt_r <= PT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_PAYLOAD: mp_r <= cfg_data[MP_W-1:0];
        CFG_TS_INC:      ts_r <= cfg_data[TS_W-1:0];
        CFG_PAYLOAD_TYP: pt_r <= cfg_data[PT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r    <= '0;
      rd_pos_r    <= '0;
      fill_r      <= '0;
      open_left_r <= '0;
      nal_count_r <= '0;
      byp_v_r     <= 1'b0;
      q_head_r    <= '0;
      q_tail_r    <= '0;
      q_num_r     <= '0;
      hlen_r      <= '0;
      hshort_r    <= 1'b0;
      use_ram_r   <= 1'b0;
      eng_r       <= 1'b0;
      inpkt_r     <= 1'b0;
      firstp_r    <= 1'b0;
      mark_r      <= 1'b0;
      pstart_r    <= 1'b0;
      hdr_r       <= HDR_NONE;
      fc_r        <= '0;
      nhdr_r      <= '0;
      run_r       <= 2'd0;
      held_v_r    <= 1'b0;
    end else begin
      wr_pos_r    <= wr_pos_nxt;
      rd_pos_r    <= rd_pos_nxt;
      fill_r      <= fill_nxt;
      open_left_r <= open_left_nxt;
      nal_count_r <= nal_count_nxt;
      byp_v_r     <= byp_v_nxt;
      q_head_r    <= q_head_nxt;
      q_tail_r    <= q_tail_nxt;
      q_num_r     <= q_num_nxt;
      hlen_r      <= hlen_nxt;
      hshort_r    <= hshort_nxt;
      use_ram_r   <= use_ram_nxt;
      eng_r       <= eng_nxt;
      inpkt_r     <= inpkt_nxt;
      firstp_r    <= firstp_nxt;
      mark_r      <= mark_nxt;
      pstart_r    <= pstart_nxt;
      hdr_r       <= hdr_nxt;
      fc_r        <= fc_nxt;
      nhdr_r      <= nhdr_nxt;
      run_r       <= run_nxt;
      held_v_r    <= held_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    byp_d_r <= cmd.data;
  end

endmodule

@@ rtl/core/h264_rtp_fua_packetizer.sv @@
// Output: each result of an engine step is held in a register and goes into the
// result queue at a later engine step or at the flush that closes the run.
// Input: a new item is taken only when the front end has no pending command and
// the engine has ended its run; each held zero ahead of a byte adds a store.
// The engine reads the delay buffer through a single read port.
// Reset: synchronous, active low; all buffers read as empty straight after.
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer
// Annex B byte stream to RTP payloads: single NAL unit packets and FU-A
// fragments, with start code removal and a delay buffer per unit.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer import rtp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [7:0]           in_stream_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_packet_first,
  output logic                 out_packet_last,
  output logic                 out_marker,
  output logic [TS_W-1:0]      out_time_step,
  output logic [PT_W-1:0]      out_packet_type,
  output logic                 out_last_of_run,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  rtp_cmd_t cmd;
  logic     back_rdy, res_push, res_full;
  rtp_res_t res, head;

  // Front end: start code search and command sequencing.
  rtp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_stream_byte (in_stream_byte),
    .back_rdy       (back_rdy),
    .cmd            (cmd)
  );

  // Packet engine.
  rtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .back_rdy  (back_rdy),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  // Result queue to the output channel.
  rtp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte         = head.data;
  assign out_packet_first = head.first;
  assign out_packet_last  = head.last;
  assign out_marker       = head.marker;
  assign out_time_step    = head.time_step;
  assign out_packet_type  = head.ptype;
  assign out_last_of_run  = head.last_of_run;

endmodule
